[rtl/gbs_pkg.sv]
// gbs_pkg: shared constants, register indexes and box arithmetic helpers
// for the greedy box suppression block. No dependencies.
`default_nettype none
package gbs_pkg;

	localparam int MAX_ANCHORS_DEF = 4096;
	localparam int MAX_KEEP_DEF    = 64;

	localparam int SCORE_W  = 16;
	localparam int COORD_W  = 16;
	localparam int BOX_W    = 4 * COORD_W;
	localparam int SIZE_W   = 13;
	localparam int ANUM_W   = 12;
	localparam int CORNER_W = 17;
	localparam int CIDX_W   = 8;
	localparam int CDATA_W  = 16;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [12:0] Q12_ONE = 13'd4096;

	localparam logic [CIDX_W-1:0] REG_SCORE_THR   = 8'd0;
	localparam logic [CIDX_W-1:0] REG_OVERLAP_THR = 8'd1;
	localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS  = 8'd2;
	localparam logic [CIDX_W-1:0] REG_IMAGE_COLS  = 8'd3;

	// width of a coordinate interval, zero when inverted
	function automatic logic [15:0] span16(input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		logic signed [16:0] d;
		d = {hi[15], hi} - {lo[15], lo};
		return d[16] ? 16'd0 : d[15:0];
	endfunction

	// clamp a q3.12 coordinate to the unit interval
	function automatic logic [12:0] clamp_q12(input logic signed [15:0] c);
		logic [12:0] r;
		if (c[15]) begin
			r = 13'd0;
		end else if (c > $signed({3'b000, Q12_ONE})) begin
			r = Q12_ONE;
		end else begin
			r = c[12:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/gbs_mul.sv]
// gbs_mul: the shared registered multiplier used for areas, the overlap
// product and corner scaling. Depends on gbs_pkg.
`default_nettype none
module gbs_mul
	import gbs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0] b,
	output logic      [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule
`default_nettype wire

[rtl/greedy_box_suppression.sv]
// greedy_box_suppression: top level, anchor stores, suppression sequencer
// and result formatting. Depends on gbs_pkg and gbs_mul.
//
// Anchors are taken one per cycle until tlast closes the frame; the block
// then stops taking requests until every result of the frame is delivered.
// The frame runs a threshold sweep over the stored anchors, then for each
// pick a maximum search and an overlap sweep (each live candidate in turn,
// set by the one shared multiplier and the single read port of the stores),
// then formats each result. No clearing pass is needed after reset.
`default_nettype none
module greedy_box_suppression
	import gbs_pkg::*;
#(
	parameter int MAX_ANCHORS = MAX_ANCHORS_DEF,
	parameter int MAX_KEEP    = MAX_KEEP_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CDATA_W-1:0] cfg_data,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// anchor_score, box_lo_a, box_lo_b, box_hi_a, box_hi_b
	input  wire logic [79:0]        s_axis_tdata,
	input  wire logic               s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// confidence, anchor_number, first_corner_u, first_corner_v,
	// second_corner_u, second_corner_v
	output logic [95:0]             m_axis_tdata,
	// found, overflow
	output logic [1:0]              m_axis_tuser,
	output logic                    m_axis_tlast
);

	localparam int IW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
	localparam int CW  = $clog2(MAX_ANCHORS + 1);
	localparam int KW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KCW = $clog2(MAX_KEEP + 1);

	typedef enum logic [20:0] {
		S_LOAD = 21'h000001, S_IR  = 21'h000002, S_IC  = 21'h000004,
		S_SR   = 21'h000008, S_SC  = 21'h000010, S_SEL = 21'h000020,
		S_REF  = 21'h000040, S_REFA = 21'h000080, S_UR = 21'h000100,
		S_UA   = 21'h000200, S_UB  = 21'h000400, S_UC  = 21'h000800,
		S_UD   = 21'h001000, S_OK  = 21'h002000, S_OI  = 21'h004000,
		S_OD   = 21'h008000, S_O1  = 21'h010000, S_O2  = 21'h020000,
		S_O3   = 21'h040000, S_O4  = 21'h080000, S_OW  = 21'h100000
	} state_t;

	state_t state_q;

	logic [SCORE_W-1:0] score_thr_q, overlap_thr_q;
	logic [SIZE_W-1:0]  rows_q, cols_q;

	logic [SCORE_W-1:0] score_mem [MAX_ANCHORS];
	logic [BOX_W-1:0]   box_mem   [MAX_ANCHORS];
	logic               live_mem  [MAX_ANCHORS];
	logic [IW-1:0]      keep_mem  [MAX_KEEP];

	logic [SCORE_W-1:0] score_rd;
	logic [BOX_W-1:0]   box_rd;
	logic               live_rd;
	logic [IW-1:0]      keep_rd;

	logic [CW-1:0]  cnt_q, i_q;
	logic [KCW-1:0] kc_q, k_q;
	logic           have_q, ovf_q;
	logic [IW-1:0]  best_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [BOX_W-1:0]   ref_q, cur_q;
	logic [31:0]    ra_q, ca_q, ia_q;
	logic [15:0]    isp0_q, isp1_q;

	logic [IW-1:0]  rd_addr;
	logic           st_we, live_we, live_wd, keep_we;
	logic [IW-1:0]  live_wa;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_q;
	logic [MUL_A_W-1:0] un;
	logic [25:0]    rnd;
	logic           last_i;

	logic               out_v_q, found_q, olast_q;
	logic [SCORE_W-1:0] conf_q;
	logic [ANUM_W-1:0]  anum_q;
	logic [CORNER_W-1:0] fcu_q, fcv_q, scu_q, scv_q;

	logic s_acc, m_acc;

	assign s_axis_tready = (state_q == S_LOAD);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_acc         = m_axis_tvalid && m_axis_tready;
	assign cfg_ready     = 1'b1;
	assign st_we         = s_acc && (cnt_q < CW'(MAX_ANCHORS));
	assign last_i        = (CW'(i_q + 1'b1) == cnt_q);
	assign un            = MUL_A_W'(ra_q) + MUL_A_W'(ca_q) - MUL_A_W'(mul_q[31:0]);
	assign rnd           = mul_q[25:0] + 26'd128;

	gbs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_q)
	);

	// read address, live and keep writes and multiplier operands
	always_comb begin
		rd_addr = i_q[IW-1:0];
		live_we = 1'b0;
		live_wa = i_q[IW-1:0];
		live_wd = 1'b0;
		keep_we = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			S_IC: begin
				live_we = 1'b1;
				live_wd = (score_rd > score_thr_q);
			end
			S_SEL: begin
				rd_addr = best_q;
				if (have_q && (kc_q < KCW'(MAX_KEEP))) begin
					live_we = 1'b1;
					live_wa = best_q;
					keep_we = 1'b1;
				end
			end
			S_REF, S_UA: begin
				mul_a = MUL_A_W'(span16(box_rd[15:0], box_rd[47:32]));
				mul_b = span16(box_rd[31:16], box_rd[63:48]);
			end
			S_UB: begin
				mul_a = MUL_A_W'(isp0_q);
				mul_b = isp1_q;
			end
			S_UC: begin
				mul_a = un;
				mul_b = overlap_thr_q;
			end
			S_UD: begin
				live_we = ({ia_q, 16'd0} > mul_q[47:0]) || (mul_q[49:48] != 2'd0)
					? ({2'b00, ia_q, 16'd0} > mul_q) : 1'b0;
			end
			S_OI: rd_addr = keep_rd;
			S_OD: begin
				mul_a = MUL_A_W'(clamp_q12(box_rd[31:16]));
				mul_b = MUL_B_W'(rows_q);
			end
			S_O1: begin
				mul_a = MUL_A_W'(clamp_q12(cur_q[15:0]));
				mul_b = MUL_B_W'(cols_q);
			end
			S_O2: begin
				mul_a = MUL_A_W'(clamp_q12(cur_q[63:48]));
				mul_b = MUL_B_W'(rows_q);
			end
			S_O3: begin
				mul_a = MUL_A_W'(clamp_q12(cur_q[47:32]));
				mul_b = MUL_B_W'(cols_q);
			end
			default: begin
			end
		endcase
	end

	// anchor stores
	always_ff @(posedge clk) begin
		if (st_we) begin
			score_mem[cnt_q[IW-1:0]] <= s_axis_tdata[15:0];
			box_mem[cnt_q[IW-1:0]]   <= s_axis_tdata[79:16];
		end
		score_rd <= score_mem[rd_addr];
		box_rd   <= box_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[live_wa] <= live_wd;
		end
		live_rd <= live_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (keep_we) begin
			keep_mem[kc_q[KW-1:0]] <= best_q;
		end
		keep_rd <= keep_mem[k_q[KW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= 16'd32768;
			overlap_thr_q <= 16'd32768;
			rows_q        <= 13'd480;
			cols_q        <= 13'd640;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCORE_THR:   score_thr_q   <= cfg_data;
				REG_OVERLAP_THR: overlap_thr_q <= cfg_data;
				REG_IMAGE_ROWS:  rows_q        <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_COLS:  cols_q        <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_SC: begin
				if (live_rd && (!have_q || (score_rd >= best_score_q))) begin
					best_q       <= i_q[IW-1:0];
					best_score_q <= score_rd;
				end
			end
			S_REF: ref_q <= box_rd;
			S_REFA: ra_q <= mul_q[31:0];
			S_UA: begin
				isp0_q <= span16(
					($signed(box_rd[15:0]) > $signed(ref_q[15:0])) ? box_rd[15:0] : ref_q[15:0],
					($signed(box_rd[47:32]) < $signed(ref_q[47:32])) ? box_rd[47:32]
						: ref_q[47:32]);
				isp1_q <= span16(
					($signed(box_rd[31:16]) > $signed(ref_q[31:16])) ? box_rd[31:16]
						: ref_q[31:16],
					($signed(box_rd[63:48]) < $signed(ref_q[63:48])) ? box_rd[63:48]
						: ref_q[63:48]);
			end
			S_UB: ca_q <= mul_q[31:0];
			S_UC: ia_q <= mul_q[31:0];
			S_OI: anum_q <= ANUM_W'(keep_rd);
			S_OD: begin
				cur_q  <= box_rd;
				conf_q <= score_rd;
			end
			S_O1: fcu_q <= rnd[24:8];
			S_O2: fcv_q <= rnd[24:8];
			S_O3: scu_q <= rnd[24:8];
			S_O4: scv_q <= rnd[24:8];
			S_SEL: begin
				if (!have_q && (kc_q == '0)) begin
					conf_q <= '0;
					anum_q <= '0;
					fcu_q  <= '0;
					fcv_q  <= '0;
					scu_q  <= '0;
					scv_q  <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			i_q     <= '0;
			kc_q    <= '0;
			k_q     <= '0;
			have_q  <= 1'b0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
			found_q <= 1'b0;
			olast_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (s_acc) begin
						if (st_we) begin
							cnt_q <= CW'(cnt_q + 1'b1);
						end
						if (s_axis_tlast) begin
							i_q     <= '0;
							kc_q    <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IR;
						end
					end
				end
				S_IR: state_q <= S_IC;
				S_IC: begin
					if (last_i) begin
						i_q     <= '0;
						have_q  <= 1'b0;
						state_q <= S_SR;
					end else begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= S_IR;
					end
				end
				S_SR: state_q <= S_SC;
				S_SC: begin
					if (live_rd) begin
						have_q <= 1'b1;
					end
					if (last_i) begin
						state_q <= S_SEL;
					end else begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= S_SR;
					end
				end
				S_SEL: begin
					k_q <= '0;
					if (!have_q) begin
						if (kc_q == '0) begin
							found_q <= 1'b0;
							olast_q <= 1'b1;
							out_v_q <= 1'b1;
							state_q <= S_OW;
						end else begin
							state_q <= S_OK;
						end
					end else if (kc_q >= KCW'(MAX_KEEP)) begin
						ovf_q   <= 1'b1;
						state_q <= S_OK;
					end else begin
						kc_q    <= KCW'(kc_q + 1'b1);
						state_q <= S_REF;
					end
				end
				S_REF: state_q <= S_REFA;
				S_REFA: begin
					i_q     <= '0;
					state_q <= S_UR;
				end
				S_UR: state_q <= S_UA;
				S_UA: begin
					if (live_rd) begin
						state_q <= S_UB;
					end else if (last_i) begin
						i_q     <= '0;
						have_q  <= 1'b0;
						state_q <= S_SR;
					end else begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= S_UR;
					end
				end
				S_UB: state_q <= S_UC;
				S_UC: state_q <= S_UD;
				S_UD: begin
					if (last_i) begin
						i_q     <= '0;
						have_q  <= 1'b0;
						state_q <= S_SR;
					end else begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= S_UR;
					end
				end
				S_OK: state_q <= S_OI;
				S_OI: state_q <= S_OD;
				S_OD: state_q <= S_O1;
				S_O1: state_q <= S_O2;
				S_O2: state_q <= S_O3;
				S_O3: state_q <= S_O4;
				S_O4: begin
					found_q <= 1'b1;
					olast_q <= (KCW'(k_q + 1'b1) == kc_q);
					out_v_q <= 1'b1;
					state_q <= S_OW;
				end
				S_OW: begin
					if (m_acc) begin
						out_v_q <= 1'b0;
						if (olast_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= KCW'(k_q + 1'b1);
							state_q <= S_OK;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {scv_q, scu_q, fcv_q, fcu_q, anum_q, conf_q};
	assign m_axis_tuser  = {ovf_q && found_q, found_q};
	assign m_axis_tlast  = olast_q;

	a_no_overlap_sides: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a result is pending");

	a_keep_cap: assert property (@(posedge clk) disable iff (!arst_n)
		kc_q <= KCW'(MAX_KEEP))
		else $error("keep count beyond cap");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("empty frame result not marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (cnt_q <= CW'(MAX_ANCHORS)))
		else $error("anchor count beyond store depth");

endmodule
`default_nettype wire
